FILE: src/pbwft_pkg.sv
// Shared types and codes of the protobuf wire-format field tokenizer.
package pbwft_pkg;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_buffer;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  kind;
        logic [31:0] field_number;
        logic [2:0]  wtype;
        logic [63:0] value;
        logic        payload_last;
        logic [2:0]  error_code;
        logic        buffer_end;
    } t_out_item;

    typedef enum logic [2:0] {
        PH_TAG     = 3'd0,
        PH_VARINT  = 3'd1,
        PH_FIXED   = 3'd2,
        PH_LEN     = 3'd3,
        PH_PAYLOAD = 3'd4,
        PH_DISCARD = 3'd5
    } t_phase;

    // Result kinds.
    localparam logic [2:0] KIND_VARINT  = 3'd0;
    localparam logic [2:0] KIND_FIXED64 = 3'd1;
    localparam logic [2:0] KIND_LENGTH  = 3'd2;
    localparam logic [2:0] KIND_FIXED32 = 3'd3;
    localparam logic [2:0] KIND_PAYLOAD = 3'd4;
    localparam logic [2:0] KIND_ERROR   = 3'd5;

    // Error codes.
    localparam logic [2:0] ERR_NONE      = 3'd0;
    localparam logic [2:0] ERR_WIRE_TYPE = 3'd1;
    localparam logic [2:0] ERR_TRUNCATED = 3'd2;
    localparam logic [2:0] ERR_OVERLONG  = 3'd3;
    localparam logic [2:0] ERR_LENGTH    = 3'd4;

    // Wire types.
    localparam logic [2:0] WT_VARINT  = 3'd0;
    localparam logic [2:0] WT_FIXED64 = 3'd1;
    localparam logic [2:0] WT_LENGTH  = 3'd2;
    localparam logic [2:0] WT_FIXED32 = 3'd5;

    // Varint byte layout and limits.
    localparam logic [7:0] VARINT_DATA_MASK = 8'h7F;
    localparam logic [3:0] VARINT_LAST_IDX  = 4'd9;

endpackage

FILE: src/protobuf_wire_field_tokenizer_top.sv
// Top level of the protobuf wire-format field tokenizer: byte decoder and result register.
//
// The block takes an encoded protobuf buffer one byte per transfer and splits it into
// fields: a tag varint gives the field number and wire type, then a varint value,
// a fixed 64- or 32-bit little-endian value, or a length header followed by the payload
// bytes one by one. It returns at most one result per input byte, in the cycle after the
// byte's transfer, from a single result register. Every byte is decoded in the cycle it
// is taken, so the block sustains one byte per clock; o_in_ready falls only while a result
// sits in the result register and the downstream side holds i_out_ready low. After an
// error, the rest of the buffer is dropped silently; every byte marked as the end of the
// buffer returns the decoder to its reset state, ready for a fresh tag.
module protobuf_wire_field_tokenizer_top #(
    parameter int LEN_WIDTH = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  pbwft_pkg::t_in_item  i_in_item,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output pbwft_pkg::t_out_item o_out_item
);
    import pbwft_pkg::*;

    // Largest length that still fits in LEN_WIDTH bits, held one bit wider than a
    // varint so that a 64-bit length width works too.
    localparam logic [64:0] LenLimit = (65'd1 << LEN_WIDTH) - 65'd1;

    // Decoder state.
    t_phase                 r_phase, n_phase;
    logic [63:0]            r_acc, n_acc;
    logic [3:0]             r_seen, n_seen;
    logic [31:0]            r_fnum, n_fnum;
    logic [2:0]             r_wtype, n_wtype;
    logic [LEN_WIDTH-1:0]   r_rem, n_rem;

    // Result register.
    logic                   r_out_valid, n_out_valid;
    t_out_item              r_out, n_out;

    logic                   in_xfer;
    logic [7:0]             b;
    logic                   eob;

    // Varint step shared by the tag, value and length phases.
    logic [6:0]             v_shamt;
    logic [63:0]            v_acc;
    logic [3:0]             v_seen;
    logic                   v_skip;
    logic                   v_over;
    logic                   v_more;
    logic [63:0]            f_acc;
    logic [LEN_WIDTH-1:0]   rem_dec;

    function automatic t_out_item make_out(logic [2:0] kind, logic [31:0] fnum,
                                           logic [2:0] wt, logic [63:0] value,
                                           logic last, logic [2:0] err, logic e);
        t_out_item o;
        o.kind         = kind;
        o.field_number = fnum;
        o.wtype        = wt;
        o.value        = value;
        o.payload_last = last;
        o.error_code   = err;
        o.buffer_end   = e;
        return o;
    endfunction

    // A new byte is taken whenever the result register is empty or is being emptied.
    assign o_in_ready = !r_out_valid || i_out_ready;
    assign in_xfer    = i_in_valid && o_in_ready;
    assign b          = i_in_item.in_byte;
    assign eob        = i_in_item.end_of_buffer;

    always_comb begin
        // A varint that has already taken ten bytes takes no more; in practice the
        // tenth byte with its continuation bit set has already flagged an overlong error.
        v_skip  = r_seen > VARINT_LAST_IDX;
        v_shamt = 7'(r_seen) * 7'd7;
        v_acc   = v_skip ? r_acc : (r_acc | (64'(b & VARINT_DATA_MASK) << v_shamt));
        v_seen  = v_skip ? r_seen : r_seen + 4'd1;
        v_over  = v_skip || (b[7] && r_seen == VARINT_LAST_IDX);
        v_more  = b[7];
        // Fixed fields gather bytes little-endian at the byte count.
        f_acc   = r_acc | (64'(b) << {r_seen[2:0], 3'b000});
        rem_dec = (r_rem != '0) ? r_rem - LEN_WIDTH'(1) : r_rem;
    end

    always_comb begin
        n_phase     = r_phase;
        n_acc       = r_acc;
        n_seen      = r_seen;
        n_fnum      = r_fnum;
        n_wtype     = r_wtype;
        n_rem       = r_rem;
        n_out_valid = 1'b0;
        n_out       = r_out;

        unique case (r_phase)
            PH_TAG: begin
                n_acc  = v_acc;
                n_seen = v_seen;
                if (v_over) begin
                    n_phase     = PH_DISCARD;
                    n_out_valid = 1'b1;
                    n_out = make_out(KIND_ERROR, r_fnum, r_wtype, 64'(b), 1'b0,
                                     ERR_OVERLONG, eob);
                end else if (v_more) begin
                    if (eob) begin
                        n_phase     = PH_DISCARD;
                        n_out_valid = 1'b1;
                        n_out = make_out(KIND_ERROR, r_fnum, r_wtype, 64'(b), 1'b0,
                                         ERR_TRUNCATED, eob);
                    end
                end else begin
                    n_fnum  = v_acc[34:3];
                    n_wtype = v_acc[2:0];
                    n_acc   = '0;
                    n_seen  = '0;
                    case (v_acc[2:0])
                        WT_VARINT:  n_phase = PH_VARINT;
                        WT_FIXED64: begin
                            n_phase = PH_FIXED;
                            n_rem   = LEN_WIDTH'(8);
                        end
                        WT_FIXED32: begin
                            n_phase = PH_FIXED;
                            n_rem   = LEN_WIDTH'(4);
                        end
                        WT_LENGTH:  n_phase = PH_LEN;
                        default:    n_phase = PH_DISCARD;
                    endcase
                    if (v_acc[2:0] != WT_VARINT && v_acc[2:0] != WT_FIXED64 &&
                        v_acc[2:0] != WT_FIXED32 && v_acc[2:0] != WT_LENGTH) begin
                        n_out_valid = 1'b1;
                        n_out = make_out(KIND_ERROR, v_acc[34:3], v_acc[2:0], 64'(b),
                                         1'b0, ERR_WIRE_TYPE, eob);
                    end else if (eob) begin
                        n_phase     = PH_DISCARD;
                        n_out_valid = 1'b1;
                        n_out = make_out(KIND_ERROR, v_acc[34:3], v_acc[2:0], 64'(b),
                                         1'b0, ERR_TRUNCATED, eob);
                    end
                end
            end
            PH_VARINT: begin
                n_acc  = v_acc;
                n_seen = v_seen;
                if (v_over) begin
                    n_phase     = PH_DISCARD;
                    n_out_valid = 1'b1;
                    n_out = make_out(KIND_ERROR, r_fnum, r_wtype, 64'(b), 1'b0,
                                     ERR_OVERLONG, eob);
                end else if (v_more) begin
                    if (eob) begin
                        n_phase     = PH_DISCARD;
                        n_out_valid = 1'b1;
                        n_out = make_out(KIND_ERROR, r_fnum, r_wtype, 64'(b), 1'b0,
                                         ERR_TRUNCATED, eob);
                    end
                end else begin
                    n_out_valid = 1'b1;
                    n_out = make_out(KIND_VARINT, r_fnum, r_wtype, v_acc, 1'b0,
                                     ERR_NONE, eob);
                    n_phase = PH_TAG;
                    n_acc   = '0;
                    n_seen  = '0;
                    n_fnum  = '0;
                    n_wtype = '0;
                    n_rem   = '0;
                end
            end
            PH_FIXED: begin
                n_acc  = f_acc;
                n_seen = r_seen + 4'd1;
                n_rem  = rem_dec;
                if (rem_dec == '0) begin
                    n_out_valid = 1'b1;
                    n_out = make_out((r_wtype == WT_FIXED64) ? KIND_FIXED64 : KIND_FIXED32,
                                     r_fnum, r_wtype, f_acc, 1'b0, ERR_NONE, eob);
                    n_phase = PH_TAG;
                    n_acc   = '0;
                    n_seen  = '0;
                    n_fnum  = '0;
                    n_wtype = '0;
                end else if (eob) begin
                    n_phase     = PH_DISCARD;
                    n_out_valid = 1'b1;
                    n_out = make_out(KIND_ERROR, r_fnum, r_wtype, 64'(b), 1'b0,
                                     ERR_TRUNCATED, eob);
                end
            end
            PH_LEN: begin
                n_acc  = v_acc;
                n_seen = v_seen;
                if (v_over) begin
                    n_phase     = PH_DISCARD;
                    n_out_valid = 1'b1;
                    n_out = make_out(KIND_ERROR, r_fnum, r_wtype, 64'(b), 1'b0,
                                     ERR_OVERLONG, eob);
                end else if (v_more) begin
                    if (eob) begin
                        n_phase     = PH_DISCARD;
                        n_out_valid = 1'b1;
                        n_out = make_out(KIND_ERROR, r_fnum, r_wtype, 64'(b), 1'b0,
                                         ERR_TRUNCATED, eob);
                    end
                end else if ({1'b0, v_acc} > LenLimit) begin
                    n_phase     = PH_DISCARD;
                    n_out_valid = 1'b1;
                    n_out = make_out(KIND_ERROR, r_fnum, r_wtype, 64'(b), 1'b0,
                                     ERR_LENGTH, eob);
                end else if (v_acc == '0) begin
                    // An empty field gives its header and nothing more.
                    n_out_valid = 1'b1;
                    n_out = make_out(KIND_LENGTH, r_fnum, r_wtype, 64'd0, 1'b0,
                                     ERR_NONE, eob);
                    n_phase = PH_TAG;
                    n_acc   = '0;
                    n_seen  = '0;
                    n_fnum  = '0;
                    n_wtype = '0;
                    n_rem   = '0;
                end else if (eob) begin
                    n_phase     = PH_DISCARD;
                    n_out_valid = 1'b1;
                    n_out = make_out(KIND_ERROR, r_fnum, r_wtype, 64'(b), 1'b0,
                                     ERR_TRUNCATED, eob);
                end else begin
                    n_out_valid = 1'b1;
                    n_out = make_out(KIND_LENGTH, r_fnum, r_wtype, v_acc, 1'b0,
                                     ERR_NONE, eob);
                    n_rem   = v_acc[LEN_WIDTH-1:0];
                    n_acc   = '0;
                    n_seen  = '0;
                    n_phase = PH_PAYLOAD;
                end
            end
            PH_PAYLOAD: begin
                n_rem = rem_dec;
                if (rem_dec != '0 && eob) begin
                    n_phase     = PH_DISCARD;
                    n_out_valid = 1'b1;
                    n_out = make_out(KIND_ERROR, r_fnum, r_wtype, 64'(b), 1'b0,
                                     ERR_TRUNCATED, eob);
                end else begin
                    n_out_valid = 1'b1;
                    n_out = make_out(KIND_PAYLOAD, r_fnum, r_wtype, 64'(b),
                                     rem_dec == '0, ERR_NONE, eob);
                    if (rem_dec == '0) begin
                        n_phase = PH_TAG;
                        n_acc   = '0;
                        n_seen  = '0;
                        n_fnum  = '0;
                        n_wtype = '0;
                    end
                end
            end
            PH_DISCARD: begin
            end
            default: begin
                n_phase = PH_TAG;
                n_acc   = '0;
                n_seen  = '0;
                n_fnum  = '0;
                n_wtype = '0;
                n_rem   = '0;
            end
        endcase

        // The last byte of a buffer always leaves the decoder in its reset state.
        if (eob) begin
            n_phase = PH_TAG;
            n_acc   = '0;
            n_seen  = '0;
            n_fnum  = '0;
            n_wtype = '0;
            n_rem   = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_TAG;
            r_acc       <= '0;
            r_seen      <= '0;
            r_fnum      <= '0;
            r_wtype     <= '0;
            r_rem       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_xfer) begin
                r_phase     <= n_phase;
                r_acc       <= n_acc;
                r_seen      <= n_seen;
                r_fnum      <= n_fnum;
                r_wtype     <= n_wtype;
                r_rem       <= n_rem;
                r_out_valid <= n_out_valid;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // The result payload needs no reset; it is loaded with every accepted byte that gives a result.
    always_ff @(posedge i_clk) begin
        if (in_xfer && n_out_valid) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    // A byte that ends the buffer leaves the decoder expecting a fresh tag.
    a_eob_resets: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer && i_in_item.end_of_buffer |=> r_phase == PH_TAG && r_seen == 4'd0)
        else $error("decoder not back at tag phase after end of buffer");

    // Only error results carry an error code.
    a_err_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.kind != KIND_ERROR |-> o_out_item.error_code == ERR_NONE)
        else $error("error code on a non-error result");

    // The last-byte flag appears only on payload bytes.
    a_last_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.payload_last |-> o_out_item.kind == KIND_PAYLOAD)
        else $error("payload_last on a result that is not a payload byte");

endmodule
